[rtl/chained_hash_table_with_doubling_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash table
// Shared helpers that wrap concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_WITH_DOUBLING_MACROS_SVH
`define CHAINED_HASH_TABLE_WITH_DOUBLING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chd_pkg.sv]
// ----------------------------------------------------------------------------
// chd_pkg
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int DEF_MAX_SLOTS   = 2048;
  localparam int DEF_BUCKET_WAYS = 3;
  localparam int DEF_KEY_BITS    = 24;
  localparam int DEF_HANDLE_BITS = 16;
  localparam int RESET_SLOTS     = 101;
  localparam int CFG_W           = 12;
  localparam int STATUS_W        = 3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DOUBLED  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_DELETED  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_OP,
    S_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_WALK_RD,
    S_WALK_LD,
    S_WALK_SEL,
    S_WALK_MOD,
    S_WALK_PRD,
    S_WALK_PL,
    S_WALK_NXT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_INSERT,
    WR_DELETE,
    WR_WALK
  } wr_op_t;

  typedef enum logic {
    RD_TGT,
    RD_ROW
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    cfg_take;
    logic    mod_start;
    logic    mod_walk;
    logic    tgt_load;
    logic    bkt_load;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    logic    scr_wr;
    logic    walk_load;
    logic    k_clr;
    logic    k_inc;
    logic    row_clr;
    logic    row_inc;
    logic    dbl;
    logic    status_set;
    status_t status_code;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic func;
    logic mod_done;
    logic del_hit;
    logic overfull_nz;
    logic grow_ok;
    logic row_last_all;
    logic row_last_cur;
    logic row_last_half;
    logic k_last;
    logic walk_valid;
    logic out_busy;
    logic out_take;
  } dp_stat_t;

endpackage

[rtl/chd_ifs.sv]
// ----------------------------------------------------------------------------
// chd interfaces
// Valid/ready channels for requests, responses and the configuration write.
// ----------------------------------------------------------------------------
interface chd_req_if #(
  parameter int KEY_BITS    = chd_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = chd_pkg::DEF_HANDLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [KEY_BITS-1:0]    key;
  logic [HANDLE_BITS-1:0] record_handle;

  modport source (output valid, func, key, record_handle, input ready);
  modport sink   (input valid, func, key, record_handle, output ready);
endinterface

interface chd_rsp_if #(
  parameter int MAX_SLOTS = chd_pkg::DEF_MAX_SLOTS
);
  logic                           valid;
  logic                           ready;
  logic [chd_pkg::STATUS_W-1:0]   status;
  logic [$clog2(MAX_SLOTS)-1:0]   bucket;
  logic [$clog2(MAX_SLOTS):0]     slot_count;

  modport source (output valid, status, bucket, slot_count, input ready);
  modport sink   (input valid, status, bucket, slot_count, output ready);
endinterface

interface chd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [chd_pkg::CFG_W-1:0] initial_slots;

  modport source (output valid, initial_slots, input ready);
  modport sink   (input valid, initial_slots, output ready);
endinterface

[rtl/chd_mod.sv]
// ----------------------------------------------------------------------------
// chd_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chd_mod #(
  parameter int DIVIDEND_W = chd_pkg::DEF_KEY_BITS,
  parameter int DIVISOR_W  = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  rem
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W-1:0]  rem_next;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per bit keeps it in range.
  always_comb begin
    trial = {rem, dvd[DIVIDEND_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIVISOR_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DIVIDEND_W-2:0], 1'b0};
    end
  end

endmodule

[rtl/chd_dp.sv]
// ----------------------------------------------------------------------------
// chd_dp
// Datapath: entry store, rehash scratch, remainder unit and result register.
// ----------------------------------------------------------------------------
module chd_dp #(
  parameter int MAX_SLOTS   = chd_pkg::DEF_MAX_SLOTS,
  parameter int BUCKET_WAYS = chd_pkg::DEF_BUCKET_WAYS,
  parameter int KEY_BITS    = chd_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = chd_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  chd_pkg::ctrl_cmd_t            cmd,
  output chd_pkg::dp_stat_t             st,
  input  logic                          req_func,
  input  logic [KEY_BITS-1:0]           req_key,
  input  logic [HANDLE_BITS-1:0]        req_handle,
  input  logic [chd_pkg::CFG_W-1:0]     cfg_slots,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output logic [chd_pkg::STATUS_W-1:0]  rsp_status,
  output logic [$clog2(MAX_SLOTS)-1:0]  rsp_bucket,
  output logic [$clog2(MAX_SLOTS):0]    rsp_slot_count
);

  localparam int BKT_W   = $clog2(MAX_SLOTS);
  localparam int SLOT_W  = BKT_W + 1;
  localparam int ENT_W   = 1 + KEY_BITS + HANDLE_BITS;
  localparam int WAY_W   = $clog2(BUCKET_WAYS + 1);
  localparam int POS_W   = $clog2(BUCKET_WAYS);
  localparam int RST_SLOTS =
    (chd_pkg::RESET_SLOTS > MAX_SLOTS) ? MAX_SLOTS : chd_pkg::RESET_SLOTS;

  typedef logic [BUCKET_WAYS-1:0][ENT_W-1:0] row_t;

  row_t store_mem [MAX_SLOTS];
  row_t scr_mem   [MAX_SLOTS];
  row_t store_rdata;
  row_t scr_rdata;
  row_t walk_row;
  row_t wr_row;
  row_t placed;
  row_t deleted;

  logic                   in_func;
  logic [KEY_BITS-1:0]    in_key;
  logic [HANDLE_BITS-1:0] in_handle;
  logic [BKT_W-1:0]       tgt;
  logic [BKT_W-1:0]       bkt;
  logic [SLOT_W-1:0]      slots;
  logic [SLOT_W-1:0]      slots_next;
  logic [SLOT_W-1:0]      overfull;
  logic [BKT_W-1:0]       row;
  logic [WAY_W-1:0]       k;
  chd_pkg::status_t       status;

  logic [BKT_W-1:0]       rd_addr;
  logic [BKT_W-1:0]       wr_addr;
  logic                   wr_en;
  logic [POS_W-1:0]       sel_way;
  logic [ENT_W-1:0]       walk_ent;
  logic [ENT_W-1:0]       new_ent;
  logic [KEY_BITS-1:0]    mod_dvd;
  logic                   mod_done;
  logic [SLOT_W-1:0]      mod_rem;
  logic [WAY_W-1:0]       fill;
  logic                   run;
  logic                   fill_of;
  logic                   hit0;
  logic                   hit1;
  logic                   was_full;

  // Remainder unit, shared by the request path and the rehash walk.
  assign sel_way  = (k == WAY_W'(BUCKET_WAYS)) ? '0 : k[POS_W-1:0];
  assign walk_ent = walk_row[sel_way];
  assign mod_dvd  = cmd.mod_walk ? walk_ent[KEY_BITS+HANDLE_BITS-1:HANDLE_BITS] : req_key;

  chd_mod #(
    .DIVIDEND_W (KEY_BITS),
    .DIVISOR_W  (SLOT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (slots),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Bucket update logic on the row just read.
  always_comb begin
    new_ent = cmd.wr_op == chd_pkg::WR_WALK ? walk_ent : {1'b1, in_key, in_handle};
    fill = '0;
    run  = 1'b1;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (run && store_rdata[w][ENT_W-1]) begin
        fill = fill + WAY_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    placed  = store_rdata;
    fill_of = 1'b0;
    if (fill < WAY_W'(BUCKET_WAYS)) begin
      placed[fill[POS_W-1:0]] = new_ent;
      fill_of = (fill == WAY_W'(BUCKET_WAYS - 1));
    end else begin
      placed[BUCKET_WAYS-1] = new_ent;
    end
    was_full = (fill == WAY_W'(BUCKET_WAYS));
    hit0 = store_rdata[0][ENT_W-1] &&
           (store_rdata[0][KEY_BITS+HANDLE_BITS-1:HANDLE_BITS] == in_key);
    hit1 = !hit0 && store_rdata[1][ENT_W-1] &&
           (store_rdata[1][KEY_BITS+HANDLE_BITS-1:HANDLE_BITS] == in_key);
    deleted = store_rdata;
    if (hit0) begin
      for (int w = 0; w < BUCKET_WAYS - 1; w++) begin
        deleted[w] = store_rdata[w+1];
      end
      deleted[BUCKET_WAYS-1] = '0;
    end else if (hit1) begin
      for (int w = 1; w < BUCKET_WAYS; w++) begin
        deleted[w] = '0;
      end
    end
  end

  always_comb begin
    rd_addr = (cmd.rd_sel == chd_pkg::RD_ROW) ? row : tgt;
    wr_addr = tgt;
    wr_row  = placed;
    wr_en   = 1'b1;
    case (cmd.wr_op)
      chd_pkg::WR_ZERO: begin
        wr_addr = row;
        wr_row  = '0;
      end
      chd_pkg::WR_INSERT: wr_row = placed;
      chd_pkg::WR_WALK:   wr_row = placed;
      chd_pkg::WR_DELETE: wr_row = deleted;
      default:            wr_en  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_row;
    end
    store_rdata <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.scr_wr) begin
      scr_mem[row] <= store_rdata;
    end
    scr_rdata <= scr_mem[row];
  end

  // Slot count after a configuration write, clamped to the legal range.
  always_comb begin
    if (cfg_slots == '0) begin
      slots_next = SLOT_W'(1);
    end else if (32'(cfg_slots) > MAX_SLOTS) begin
      slots_next = SLOT_W'(MAX_SLOTS);
    end else begin
      slots_next = SLOT_W'(cfg_slots);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots     <= SLOT_W'(RST_SLOTS);
      overfull  <= '0;
      row       <= '0;
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cfg_take) begin
        slots    <= slots_next;
        overfull <= '0;
      end else if (cmd.dbl) begin
        slots    <= {slots[SLOT_W-2:0], 1'b0};
        overfull <= '0;
      end else if ((cmd.wr_op == chd_pkg::WR_INSERT || cmd.wr_op == chd_pkg::WR_WALK) &&
                   fill_of) begin
        overfull <= overfull + SLOT_W'(1);
      end else if (cmd.wr_op == chd_pkg::WR_DELETE && (hit0 || hit1) && was_full &&
                   overfull != '0) begin
        overfull <= overfull - SLOT_W'(1);
      end
      if (cmd.row_clr) begin
        row <= '0;
      end else if (cmd.row_inc) begin
        row <= row + BKT_W'(1);
      end
      if (cmd.k_clr) begin
        k <= WAY_W'(1);
      end else if (cmd.k_inc) begin
        k <= k + WAY_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_func   <= req_func;
      in_key    <= req_key;
      in_handle <= req_handle;
    end
    if (cmd.tgt_load) begin
      tgt <= mod_rem[BKT_W-1:0];
    end
    if (cmd.bkt_load) begin
      bkt <= mod_rem[BKT_W-1:0];
    end
    if (cmd.walk_load) begin
      walk_row <= scr_rdata;
    end
    if (cmd.status_set) begin
      status <= cmd.status_code;
    end
    if (cmd.out_load) begin
      rsp_status     <= status;
      rsp_bucket     <= bkt;
      rsp_slot_count <= slots;
    end
  end

  always_comb begin
    st.func          = in_func;
    st.mod_done      = mod_done;
    st.del_hit       = hit0 || hit1;
    st.overfull_nz   = (overfull != '0);
    st.grow_ok       = ({slots, 1'b0} <= (SLOT_W+1)'(MAX_SLOTS));
    st.row_last_all  = (row == BKT_W'(MAX_SLOTS - 1));
    st.row_last_cur  = ({1'b0, row} == slots - SLOT_W'(1));
    st.row_last_half = ({1'b0, row} == (slots >> 1) - SLOT_W'(1));
    st.k_last        = (k == WAY_W'(BUCKET_WAYS));
    st.walk_valid    = walk_ent[ENT_W-1];
    st.out_busy      = rsp_valid;
    st.out_take      = rsp_valid && rsp_ready;
  end

endmodule

[rtl/chd_ctrl.sv]
// ----------------------------------------------------------------------------
// chd_ctrl
// Controller state machine: request sequencing, clearing pass and rehash.
// ----------------------------------------------------------------------------
`include "chained_hash_table_with_doubling_macros.svh"

module chd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               cfg_valid,
  output logic               req_ready,
  output logic               cfg_ready,
  input  chd_pkg::dp_stat_t  st,
  output chd_pkg::ctrl_cmd_t cmd
);

  chd_pkg::state_t state;
  chd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      chd_pkg::S_CLEAR: begin
        if (st.row_last_all) state_next = chd_pkg::S_IDLE;
      end
      chd_pkg::S_IDLE: begin
        if (cfg_valid) begin
          state_next = chd_pkg::S_CLEAR;
        end else if (req_valid) begin
          state_next = chd_pkg::S_MOD;
        end
      end
      chd_pkg::S_MOD: begin
        if (st.mod_done) state_next = chd_pkg::S_RD;
      end
      chd_pkg::S_RD: state_next = chd_pkg::S_OP;
      chd_pkg::S_OP: state_next = chd_pkg::S_CHK;
      chd_pkg::S_CHK: begin
        if (st.func == chd_pkg::FUNC_INSERT && st.overfull_nz && st.grow_ok) begin
          state_next = chd_pkg::S_COPY_RD;
        end else begin
          state_next = chd_pkg::S_DONE;
        end
      end
      chd_pkg::S_COPY_RD: state_next = chd_pkg::S_COPY_WR;
      chd_pkg::S_COPY_WR: begin
        state_next = st.row_last_cur ? chd_pkg::S_WALK_RD : chd_pkg::S_COPY_RD;
      end
      chd_pkg::S_WALK_RD: state_next = chd_pkg::S_WALK_LD;
      chd_pkg::S_WALK_LD: state_next = chd_pkg::S_WALK_SEL;
      chd_pkg::S_WALK_SEL: begin
        state_next = st.walk_valid ? chd_pkg::S_WALK_MOD : chd_pkg::S_WALK_NXT;
      end
      chd_pkg::S_WALK_MOD: begin
        if (st.mod_done) state_next = chd_pkg::S_WALK_PRD;
      end
      chd_pkg::S_WALK_PRD: state_next = chd_pkg::S_WALK_PL;
      chd_pkg::S_WALK_PL:  state_next = chd_pkg::S_WALK_NXT;
      chd_pkg::S_WALK_NXT: begin
        if (!st.k_last) begin
          state_next = chd_pkg::S_WALK_SEL;
        end else if (st.row_last_half) begin
          state_next = chd_pkg::S_DONE;
        end else begin
          state_next = chd_pkg::S_WALK_RD;
        end
      end
      chd_pkg::S_DONE: begin
        if (!st.out_busy || st.out_take) state_next = chd_pkg::S_IDLE;
      end
      default: state_next = chd_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = chd_pkg::RD_TGT;
    cmd.wr_op       = chd_pkg::WR_NONE;
    cmd.status_code = chd_pkg::ST_INSERTED;
    req_ready       = 1'b0;
    cfg_ready       = 1'b0;
    case (state)
      chd_pkg::S_CLEAR: begin
        cmd.rd_sel = chd_pkg::RD_ROW;
        cmd.wr_op  = chd_pkg::WR_ZERO;
        if (st.row_last_all) begin
          cmd.row_clr = 1'b1;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      chd_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        req_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_take = 1'b1;
          cmd.row_clr  = 1'b1;
        end else if (req_valid) begin
          cmd.accept    = 1'b1;
          cmd.mod_start = 1'b1;
        end
      end
      chd_pkg::S_MOD: begin
        if (st.mod_done) begin
          cmd.tgt_load = 1'b1;
          cmd.bkt_load = 1'b1;
        end
      end
      chd_pkg::S_OP: begin
        if (st.func == chd_pkg::FUNC_DELETE) begin
          cmd.wr_op       = chd_pkg::WR_DELETE;
          cmd.status_set  = 1'b1;
          cmd.status_code = st.del_hit ? chd_pkg::ST_DELETED : chd_pkg::ST_NOTFOUND;
        end else begin
          cmd.wr_op = chd_pkg::WR_INSERT;
        end
      end
      chd_pkg::S_CHK: begin
        if (st.func == chd_pkg::FUNC_INSERT) begin
          if (!st.overfull_nz) begin
            cmd.status_set  = 1'b1;
            cmd.status_code = chd_pkg::ST_INSERTED;
          end else if (st.grow_ok) begin
            cmd.row_clr = 1'b1;
          end else begin
            cmd.status_set  = 1'b1;
            cmd.status_code = chd_pkg::ST_REFUSED;
          end
        end
      end
      chd_pkg::S_COPY_RD: cmd.rd_sel = chd_pkg::RD_ROW;
      chd_pkg::S_COPY_WR: begin
        cmd.rd_sel = chd_pkg::RD_ROW;
        cmd.wr_op  = chd_pkg::WR_ZERO;
        cmd.scr_wr = 1'b1;
        if (st.row_last_cur) begin
          cmd.dbl     = 1'b1;
          cmd.row_clr = 1'b1;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      chd_pkg::S_WALK_LD: begin
        cmd.walk_load = 1'b1;
        cmd.k_clr     = 1'b1;
      end
      chd_pkg::S_WALK_SEL: begin
        if (st.walk_valid) begin
          cmd.mod_start = 1'b1;
          cmd.mod_walk  = 1'b1;
        end
      end
      chd_pkg::S_WALK_MOD: begin
        cmd.mod_walk = 1'b1;
        if (st.mod_done) cmd.tgt_load = 1'b1;
      end
      chd_pkg::S_WALK_PL: begin
        cmd.mod_walk = 1'b1;
        cmd.wr_op    = chd_pkg::WR_WALK;
      end
      chd_pkg::S_WALK_NXT: begin
        if (!st.k_last) begin
          cmd.k_inc = 1'b1;
        end else if (st.row_last_half) begin
          cmd.row_clr     = 1'b1;
          cmd.status_set  = 1'b1;
          cmd.status_code = chd_pkg::ST_DOUBLED;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      chd_pkg::S_DONE: begin
        if (!st.out_busy || st.out_take) cmd.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  `CHD_ASSERT_IMP(a_mod_done_waited, clk, rst, st.mod_done, (state == chd_pkg::S_MOD || state == chd_pkg::S_WALK_MOD), "remainder finished outside a wait state")
  `CHD_ASSERT_NXT(a_dbl_to_walk, clk, rst, cmd.dbl, state == chd_pkg::S_WALK_RD, "doubling not followed by the rehash walk")
  `CHD_ASSERT_IMP(a_copy_needs_room, clk, rst, state == chd_pkg::S_COPY_WR, st.grow_ok && st.func == chd_pkg::FUNC_INSERT, "table copy started without room to grow")

endmodule

[rtl/chained_hash_table_with_doubling.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_with_doubling
// Keyed table of record handles with bounded chains and slot doubling.
// ----------------------------------------------------------------------------
// A key lands in bucket key modulo the current slot count; each bucket holds
// up to BUCKET_WAYS entries. Every request returns exactly one response beat
// with its status, the bucket it hashed to and the slot count afterwards. An
// ordinary insert or delete is paced by the bit-serial remainder unit. An
// insert that leaves any bucket full doubles the table if it may still grow
// and is refused otherwise. To double, the old table is copied to the scratch
// memory bucket by bucket, then each stored entry is rehashed through the
// same remainder unit. After reset and after each write of initial_slots a
// clearing pass over all MAX_SLOTS buckets runs before a request is taken;
// the configuration channel is ready whenever the block is idle. A finished
// response waits in its own register, so the next request may start while
// the last beat is unclaimed.
// ----------------------------------------------------------------------------
module chained_hash_table_with_doubling #(
  parameter int MAX_SLOTS   = chd_pkg::DEF_MAX_SLOTS,
  parameter int BUCKET_WAYS = chd_pkg::DEF_BUCKET_WAYS,
  parameter int KEY_BITS    = chd_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = chd_pkg::DEF_HANDLE_BITS
) (
  input logic       clk,
  input logic       rst,
  chd_req_if.sink   req,
  chd_rsp_if.source rsp,
  chd_cfg_if.sink   cfg
);

  // Commands flow from the controller to the datapath; status flows back.
  chd_pkg::ctrl_cmd_t cmd;
  chd_pkg::dp_stat_t  st;

  chd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .cfg_valid (cfg.valid),
    .req_ready (req.ready),
    .cfg_ready (cfg.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath owns both memories, the remainder unit and the response
  // register that drives the output channel.
  chd_dp #(
    .MAX_SLOTS   (MAX_SLOTS),
    .BUCKET_WAYS (BUCKET_WAYS),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .req_func       (req.func),
    .req_key        (req.key),
    .req_handle     (req.record_handle),
    .cfg_slots      (cfg.initial_slots),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_status     (rsp.status),
    .rsp_bucket     (rsp.bucket),
    .rsp_slot_count (rsp.slot_count)
  );

endmodule

[sim/chained_hash_table_with_doubling_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for chained_hash_table_with_doubling
// Drives insert and delete beats against a local copy of the chained table,
// walks several slot count settings and checks every response field.
// ----------------------------------------------------------------------------
module chained_hash_table_with_doubling_test;

  localparam int MAXS  = chd_pkg::DEF_MAX_SLOTS;
  localparam int WAYS  = chd_pkg::DEF_BUCKET_WAYS;
  localparam int DEPTH = MAXS * WAYS;

  typedef struct {
    logic        func;
    logic [23:0] key;
    logic [15:0] handle;
  } table_req_t;

  typedef struct {
    chd_pkg::status_t status;
    logic [10:0]      bucket;
    logic [11:0]      slot_count;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst;

  chd_req_if req ();
  chd_rsp_if rsp ();
  chd_cfg_if cfg ();

  chained_hash_table_with_doubling u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the table: the live entries and the copy used while rehashing.
  bit          live_v[DEPTH];
  logic [23:0] live_k[DEPTH];
  logic [15:0] live_h[DEPTH];
  bit          old_v[DEPTH];
  logic [23:0] old_k[DEPTH];
  logic [15:0] old_h[DEPTH];
  int unsigned cur_slots;
  int unsigned full_buckets;

  table_req_t  pending_reqs[$];
  table_rsp_t  awaited_rsps[$];
  logic [23:0] stored_keys[$];

  bit failed = 1'b0;
  bit calm   = 1'b0;
  bit hold_long = 1'b0;
  int n_accepted = 0;

  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) live_v[i] = 1'b0;
    full_buckets = 0;
  endfunction

  function automatic void load_slots(logic [11:0] v);
    wipe_table();
    if (v == 0) cur_slots = 1;
    else if (v > MAXS) cur_slots = MAXS;
    else cur_slots = 32'(v);
  endfunction

  function automatic int unsigned ways_used(int unsigned base);
    int unsigned n;
    n = 0;
    while (n < WAYS && live_v[base + n]) n++;
    return n;
  endfunction

  // Append to the bucket; a full bucket has its last entry replaced.
  function automatic void place(logic [23:0] k, logic [15:0] h);
    int unsigned base, n, pos;
    base = (k % cur_slots) * WAYS;
    n = ways_used(base);
    if (n < WAYS) begin
      pos = base + n;
      if (n + 1 == WAYS) full_buckets++;
    end else begin
      pos = base + WAYS - 1;
    end
    live_v[pos] = 1'b1;
    live_k[pos] = k;
    live_h[pos] = h;
  endfunction

  // Double the slot count and reinsert each old bucket: second, third, head.
  function automatic void double_slots();
    int unsigned prev, way;
    prev = cur_slots;
    for (int i = 0; i < DEPTH; i++) begin
      old_v[i] = live_v[i];
      old_k[i] = live_k[i];
      old_h[i] = live_h[i];
    end
    wipe_table();
    cur_slots = prev * 2;
    for (int b = 0; b < prev; b++) begin
      for (int j = 1; j <= WAYS; j++) begin
        way = (j == WAYS) ? 0 : j;
        if (old_v[b * WAYS + way]) place(old_k[b * WAYS + way], old_h[b * WAYS + way]);
      end
    end
  endfunction

  function automatic table_rsp_t table_update(table_req_t r);
    table_rsp_t  o;
    int unsigned base;
    bit          was_full;
    o.bucket = 11'(r.key % cur_slots);
    base = (r.key % cur_slots) * WAYS;
    if (r.func == chd_pkg::FUNC_INSERT) begin
      place(r.key, r.handle);
      o.status = chd_pkg::ST_INSERTED;
      if (full_buckets > 0) begin
        if (cur_slots * 2 <= MAXS) begin
          double_slots();
          o.status = chd_pkg::ST_DOUBLED;
        end else begin
          o.status = chd_pkg::ST_REFUSED;
        end
      end
    end else begin
      was_full = (ways_used(base) == WAYS);
      o.status = chd_pkg::ST_NOTFOUND;
      if (!live_v[base]) begin
        o.status = chd_pkg::ST_NOTFOUND;
      end else if (live_k[base] == r.key) begin
        // Deleting the head moves the rest up one place.
        for (int w = 0; w + 1 < WAYS; w++) begin
          live_v[base + w] = live_v[base + w + 1];
          live_k[base + w] = live_k[base + w + 1];
          live_h[base + w] = live_h[base + w + 1];
        end
        live_v[base + WAYS - 1] = 1'b0;
        o.status = chd_pkg::ST_DELETED;
      end else if (live_v[base + 1] && live_k[base + 1] == r.key) begin
        // Deleting the second entry drops it and everything behind it.
        for (int w = 1; w < WAYS; w++) live_v[base + w] = 1'b0;
        o.status = chd_pkg::ST_DELETED;
      end
      if (o.status == chd_pkg::ST_DELETED && was_full && full_buckets > 0) full_buckets--;
    end
    o.slot_count = 12'(cur_slots);
    return o;
  endfunction

  // Driver: offers the oldest pending beat, with random gaps between beats.
  int src_gap = 0;
  always @(posedge clk) begin
    bit         nxt_valid;
    table_req_t head;
    if (rst) begin
      req.valid         <= 1'b0;
      req.func          <= chd_pkg::FUNC_INSERT;
      req.key           <= '0;
      req.record_handle <= '0;
    end else begin
      if (req.valid && req.ready) begin
        head = pending_reqs.pop_front();
        awaited_rsps.push_back(table_update(head));
        n_accepted++;
        if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 13);
      end
      nxt_valid = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_reqs.size() > 0) begin
        nxt_valid = 1'b1;
        req.func          <= pending_reqs[0].func;
        req.key           <= pending_reqs[0].key;
        req.record_handle <= pending_reqs[0].handle;
      end
      req.valid <= nxt_valid;
    end
  end

  // Once, well into the run, the receiver holds off long enough to back up the input.
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && !hold_long && n_accepted == 150) begin
      hold_long <= 1'b1;
      hold_cnt  <= 400;
    end else if (hold_long) begin
      if (hold_cnt == 0) begin
        hold_long <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // Monitor: checks each response beat against the oldest expectation.
  int sink_gap = 0;
  always @(posedge clk) begin
    table_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t: unexpected response status=%0d bucket=%0d slots=%0d", $realtime,
                   rsp.status, rsp.bucket, rsp.slot_count);
          failed = 1'b1;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, rsp.status);
            failed = 1'b1;
          end
          if (rsp.bucket !== want.bucket) begin
            $display("%0t: bucket expected %0d actual %0d", $realtime, want.bucket, rsp.bucket);
            failed = 1'b1;
          end
          if (rsp.slot_count !== want.slot_count) begin
            $display("%0t: slot_count expected %0d actual %0d", $realtime, want.slot_count,
                     rsp.slot_count);
            failed = 1'b1;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        rsp.ready <= 1'b0;
      end else if (hold_long) begin
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 12);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic push_req(logic f, logic [23:0] k, logic [15:0] h);
    table_req_t r;
    r.func = f;
    r.key = k;
    r.handle = h;
    pending_reqs.push_back(r);
    if (f == chd_pkg::FUNC_INSERT && stored_keys.size() < 64) stored_keys.push_back(k);
  endtask

  // Sender pauses here until the block has answered every beat.
  task automatic wait_drained();
    do @(posedge clk); while (pending_reqs.size() != 0 || awaited_rsps.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_slots(logic [11:0] v);
    cfg.valid <= 1'b1;
    cfg.initial_slots <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    load_slots(v);
    stored_keys.delete();
  endtask

  // One setting: a short run of same-bucket beats, then random traffic that
  // partly lands in a handful of buckets so chains fill and the table doubles.
  task automatic run_phase(int n);
    int unsigned s, b0;
    logic [23:0] k;
    s = cur_slots;
    b0 = $urandom_range(0, s - 1);
    push_req(chd_pkg::FUNC_INSERT, 24'(b0), 16'($urandom));
    push_req(chd_pkg::FUNC_INSERT, 24'(b0 + s), 16'hffff);
    push_req(chd_pkg::FUNC_INSERT, 24'(b0 + 2 * s), 16'h0000);
    push_req(chd_pkg::FUNC_INSERT, 24'(b0 + 3 * s), 16'($urandom));
    push_req(chd_pkg::FUNC_DELETE, 24'(b0 + 2 * s), 16'($urandom));
    push_req(chd_pkg::FUNC_DELETE, 24'(b0 + s), 16'($urandom));
    push_req(chd_pkg::FUNC_DELETE, 24'(b0), 16'($urandom));
    push_req(chd_pkg::FUNC_DELETE, 24'hffffff, 16'($urandom));
    push_req(chd_pkg::FUNC_INSERT, 24'hffffff, 16'hffff);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    k = 24'($urandom);
        2, 3, 4: k = 24'(($urandom_range(0, 7) % s) + s * $urandom_range(0, 15));
        default: k = 24'($urandom_range(0, 4 * s));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        if (stored_keys.size() > 0 && $urandom_range(0, 4) != 0)
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        push_req(chd_pkg::FUNC_DELETE, k, 16'($urandom));
      end else begin
        push_req(chd_pkg::FUNC_INSERT, k, 16'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [11:0] settings[8] = '{12'd0, 12'd4095, 12'd1, 12'd1500, 12'd3, 12'd2048,
                                 12'd7, 12'd101};
    rst = 1'b1;
    cfg.valid <= 1'b0;
    cfg.initial_slots <= '0;
    load_slots(12'(chd_pkg::RESET_SLOTS));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    run_phase(70);
    foreach (settings[i]) begin
      if (i == 7) calm = 1'b1;
      write_slots(settings[i]);
      run_phase(70);
    end
    repeat (200) @(posedge clk);
    if (!failed && awaited_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/chd_pkg.sv
rtl/chd_ifs.sv
rtl/chd_mod.sv
rtl/chd_dp.sv
rtl/chd_ctrl.sv
rtl/chained_hash_table_with_doubling.sv
sim/chained_hash_table_with_doubling_test.sv
